// File: src/bne_pkg.sv
// Shared types, codes, constants and a saturation helper function for the backprop neuron engine.
// Used by bne_ctrl, bne_datapath and the top level; depends on nothing else.
`default_nettype none
package bne_pkg;
	localparam int IDX_W = 8;
	localparam int VAL_W = 16;
	localparam int ACC_W = 40;
	localparam int REG_W = 13;
	localparam int MAX_INPUTS_DEF = 256;
	localparam logic [REG_W-1:0] LR_RESET = 13'd1229;
	localparam logic [REG_W-1:0] MOM_RESET = 13'd2048;
	localparam logic [12:0] Q_ONE = 13'd4096;

	// tanh over [0, 4.0) in Q3.12: span is 14 bits, split into segments
	localparam int TANH_SEGMENTS = 64;
	localparam int SPAN_W = 14;
	localparam int SEG_W = $clog2(TANH_SEGMENTS);
	localparam int FRAC_W = SPAN_W - SEG_W;

	localparam logic [12:0] TANH_PTS [0:TANH_SEGMENTS] = '{
		13'd0,    13'd256,  13'd509,  13'd759,  13'd1003, 13'd1240, 13'd1468, 13'd1686,
		13'd1893, 13'd2088, 13'd2272, 13'd2443, 13'd2602, 13'd2748, 13'd2883, 13'd3007,
		13'd3119, 13'd3222, 13'd3315, 13'd3399, 13'd3475, 13'd3543, 13'd3604, 13'd3659,
		13'd3707, 13'd3751, 13'd3790, 13'd3825, 13'd3856, 13'd3883, 13'd3908, 13'd3929,
		13'd3949, 13'd3966, 13'd3981, 13'd3994, 13'd4006, 13'd4016, 13'd4026, 13'd4034,
		13'd4041, 13'd4048, 13'd4053, 13'd4058, 13'd4063, 13'd4067, 13'd4070, 13'd4073,
		13'd4076, 13'd4078, 13'd4080, 13'd4082, 13'd4084, 13'd4085, 13'd4086, 13'd4088,
		13'd4089, 13'd4089, 13'd4090, 13'd4091, 13'd4091, 13'd4092, 13'd4092, 13'd4093,
		13'd4093
	};

	// request codes
	localparam logic [2:0] REQ_FWD   = 3'd0;
	localparam logic [2:0] REQ_OGRAD = 3'd1;
	localparam logic [2:0] REQ_HGRAD = 3'd2;
	localparam logic [2:0] REQ_UPD   = 3'd3;
	localparam logic [2:0] REQ_LOAD  = 3'd4;

	// result kinds
	localparam logic [1:0] KIND_OUT  = 2'd0;
	localparam logic [1:0] KIND_GRAD = 2'd1;
	localparam logic [1:0] KIND_WGT  = 2'd2;

	// register index (paddr bit 2)
	localparam logic REG_LR  = 1'b0;
	localparam logic REG_MOM = 1'b1;

	typedef struct packed {
		logic accept;
		logic p1;
		logic p2;
		logic p3;
		logic p4;
		logic p5;
		logic p6;
		logic emit;
	} bne_cmd_t;

	typedef struct packed {
		logic has_result;
		logic out_busy;
	} bne_stat_t;

	function automatic logic signed [VAL_W-1:0] sat16(input logic signed [63:0] v);
		if (v > 64'sd32767)
			return 16'sh7fff;
		else if (v < -64'sd32768)
			return 16'sh8000;
		else
			return v[VAL_W-1:0];
	endfunction
endpackage
`default_nettype wire

// File: src/bne_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bne_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: src/bne_ctrl.sv
// Sequencer for the neuron engine: walks each accepted beat through six
// datapath phases and a result slot. Depends on bne_pkg.
`default_nettype none
module bne_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire bne_pkg::bne_stat_t stat,
	output bne_pkg::bne_cmd_t       cmd
);
	import bne_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_P1   = 8'b0000_0010,
		ST_P2   = 8'b0000_0100,
		ST_P3   = 8'b0000_1000,
		ST_P4   = 8'b0001_0000,
		ST_P5   = 8'b0010_0000,
		ST_P6   = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   stall;

	// hold a beat with a result in the result slot while the output register is still occupied
	assign stall = stat.has_result && stat.out_busy;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_P1;
			ST_P1:   state_d = ST_P2;
			ST_P2:   state_d = ST_P3;
			ST_P3:   state_d = ST_P4;
			ST_P4:   state_d = ST_P5;
			ST_P5:   state_d = ST_P6;
			ST_P6:   state_d = ST_DONE;
			ST_DONE: if (!stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	assign s_tready   = (state_q == ST_IDLE);
	assign cmd.accept = (state_q == ST_IDLE) && s_tvalid;
	assign cmd.p1     = (state_q == ST_P1);
	assign cmd.p2     = (state_q == ST_P2);
	assign cmd.p3     = (state_q == ST_P3);
	assign cmd.p4     = (state_q == ST_P4);
	assign cmd.p5     = (state_q == ST_P5);
	assign cmd.p6     = (state_q == ST_P6);
	assign cmd.emit   = (state_q == ST_DONE) && !stall;

`ifndef SYNTHESIS
	a_accept_p1: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == ST_P1)
		else $error("accepted beat did not start phase 1");
	a_hold_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && stall) |=> state_q == ST_DONE)
		else $error("left result slot while output was busy");
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> state_q == ST_IDLE)
		else $error("no return to idle after result slot");
`endif
endmodule
`default_nettype wire

// File: src/bne_datapath.sv
// Datapath of the neuron engine: weight and delta stores, accumulator,
// tanh, gradient and momentum update arithmetic, output register.
// Depends on bne_pkg and bne_ram.
`default_nettype none
module bne_datapath #(
	parameter int MAX_INPUTS = bne_pkg::MAX_INPUTS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire bne_pkg::bne_cmd_t                 cmd,
	output bne_pkg::bne_stat_t                     stat,
	input  wire logic [2:0]                        in_req,
	input  wire logic [bne_pkg::IDX_W-1:0]         in_idx,
	input  wire logic signed [bne_pkg::VAL_W-1:0]  in_a,
	input  wire logic signed [bne_pkg::VAL_W-1:0]  in_b,
	input  wire logic                              in_last,
	input  wire logic [bne_pkg::REG_W-1:0]         lr,
	input  wire logic [bne_pkg::REG_W-1:0]         mom,
	input  wire logic                              m_tready,
	output logic                                   m_tvalid,
	output logic [1:0]                             m_kind,
	output logic [bne_pkg::IDX_W-1:0]              m_index,
	output logic signed [bne_pkg::VAL_W-1:0]       m_value
);
	import bne_pkg::*;

	localparam int AW = $clog2(MAX_INPUTS);

	// captured beat
	logic [2:0]              req_q;
	logic [IDX_W-1:0]        idx_q;
	logic signed [VAL_W-1:0] a_q, b_q;
	logic                    last_q, inr_q, dv_q;

	// neuron state
	logic signed [ACC_W-1:0] acc_q;
	logic signed [VAL_W-1:0] y_q, grad_q;
	logic [MAX_INPUTS-1:0]   dvld_q;

	// scratch
	logic signed [31:0]      prod_q;
	logic [12:0]             d_q;
	logic signed [16:0]      diff_q;
	logic signed [29:0]      m1_q, m2_q;
	logic signed [46:0]      t_q;
	logic signed [VAL_W-1:0] wt_q, dnew_q, wres_q;
	logic signed [33:0]      phi_q;
	logic                    neg_q, sat_q;
	logic [SPAN_W-1:0]       s_q;
	logic                    out_valid_q;

	logic                    in_inr;
	logic [AW-1:0]           raddr, waddr;
	logic signed [VAL_W-1:0] w_rd, d_rd, dl;
	logic                    we;
	logic signed [VAL_W-1:0] w_wdata, d_wdata;
	logic signed [ACC_W:0]   acc_sum;
	logic signed [ACC_W-1:0] acc_sat;
	logic [ACC_W-1:0]        absv;
	logic [SEG_W-1:0]        seg;
	logic [FRAC_W-1:0]       frac;
	logic [12:0]             yk, yk1, ymag;
	logic [12+FRAC_W:0]      dyf;
	logic signed [VAL_W-1:0] y_new;
	logic signed [55:0]      hsum;
	logic                    is_fwd, is_og, is_hg, is_upd, is_load;

	assign in_inr = int'(in_idx) < MAX_INPUTS;
	assign raddr  = AW'(in_idx);
	assign waddr  = AW'(idx_q);

	assign is_fwd  = (req_q == REQ_FWD);
	assign is_og   = (req_q == REQ_OGRAD);
	assign is_hg   = (req_q == REQ_HGRAD);
	assign is_upd  = (req_q == REQ_UPD);
	assign is_load = (req_q == REQ_LOAD);

	// load writes in phase 1, update writes in phase 5
	assign we      = inr_q && ((cmd.p1 && is_load) || (cmd.p5 && is_upd));
	assign w_wdata = is_load ? a_q : wres_q;
	assign d_wdata = is_load ? '0 : dnew_q;

	bne_ram #(.WIDTH(VAL_W), .DEPTH(MAX_INPUTS)) u_wram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(w_wdata),
		.raddr(raddr), .rdata(w_rd)
	);

	bne_ram #(.WIDTH(VAL_W), .DEPTH(MAX_INPUTS)) u_dram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(d_wdata),
		.raddr(raddr), .rdata(d_rd)
	);

	// a delta entry never written reads as zero
	assign dl = dv_q ? d_rd : '0;

	// saturating accumulate
	assign acc_sum = {acc_q[ACC_W-1], acc_q} + (ACC_W+1)'(prod_q);
	always_comb begin
		if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
			acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		else
			acc_sat = acc_sum[ACC_W-1:0];
	end

	// magnitude of accumulator, Q3.12 after the shift
	assign absv = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);

	// piecewise-linear tanh
	assign seg   = s_q[SPAN_W-1:FRAC_W];
	assign frac  = s_q[FRAC_W-1:0];
	assign yk    = TANH_PTS[seg];
	assign yk1   = TANH_PTS[(SEG_W+1)'(seg) + (SEG_W+1)'(1)];
	assign dyf   = (yk1 - yk) * frac;
	assign ymag  = sat_q ? Q_ONE : 13'(yk + 13'(dyf >> FRAC_W));
	assign y_new = neg_q ? -VAL_W'($signed({1'b0, ymag})) : VAL_W'($signed({1'b0, ymag}));

	// hidden gradient: acc * d split into high and low halves
	assign hsum = ({{22{phi_q[33]}}, phi_q} <<< 20)
		+ 56'($signed({1'b0, acc_q[19:0]}) * $signed({1'b0, d_q}));

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q  <= in_req;
			idx_q  <= in_idx;
			a_q    <= in_a;
			b_q    <= in_b;
			last_q <= in_last;
			inr_q  <= in_inr;
			dv_q   <= in_inr ? dvld_q[raddr] : 1'b0;
		end
		if (cmd.p1) begin
			unique case (req_q)
				REQ_FWD:   prod_q <= a_q * (inr_q ? w_rd : 16'sd0);
				REQ_OGRAD: prod_q <= y_q * y_q;
				REQ_HGRAD: prod_q <= a_q * b_q;
				REQ_UPD: begin
					m1_q <= $signed({1'b0, lr}) * a_q;
					m2_q <= $signed({1'b0, mom}) * dl;
					wt_q <= w_rd;
				end
				default: ;
			endcase
		end
		if (cmd.p2) begin
			if (is_og) begin
				d_q    <= Q_ONE - prod_q[24:12];
				diff_q <= 17'(a_q) - 17'(y_q);
			end
			if (is_upd)
				t_q <= 47'(m1_q * grad_q) + (47'(m2_q) <<< 12);
		end
		if (cmd.p3) begin
			if (is_fwd) begin
				neg_q <= acc_q[ACC_W-1];
				sat_q <= |absv[ACC_W-1:12+SPAN_W];
				s_q   <= absv[12+SPAN_W-1:12];
			end
			if (is_hg)
				prod_q <= y_q * y_q;
			if (is_og)
				prod_q <= 32'(diff_q * $signed({1'b0, d_q}));
			if (is_upd)
				dnew_q <= sat16(64'(t_q >>> 24));
		end
		if (cmd.p4) begin
			if (is_hg)
				d_q <= Q_ONE - prod_q[24:12];
			if (is_upd)
				wres_q <= sat16(64'(wt_q) + 64'(dnew_q));
		end
		if (cmd.p5 && is_hg)
			phi_q <= $signed(acc_q[ACC_W-1:20]) * $signed({1'b0, d_q});
		// a beat without result must not touch a beat still waiting
		if (cmd.emit && stat.has_result) begin
			m_index <= is_upd ? idx_q : '0;
			unique case (req_q)
				REQ_FWD: begin
					m_kind  <= KIND_OUT;
					m_value <= y_q;
				end
				REQ_UPD: begin
					m_kind  <= KIND_WGT;
					m_value <= wres_q;
				end
				default: begin
					m_kind  <= KIND_GRAD;
					m_value <= grad_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			y_q         <= '0;
			grad_q      <= '0;
			dvld_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.p2 && (is_fwd || is_hg))
				acc_q <= acc_sat;
			if (cmd.p4 && is_fwd && last_q) begin
				y_q   <= y_new;
				acc_q <= '0;
			end
			if (cmd.p4 && is_og)
				grad_q <= sat16(64'(prod_q >>> 12));
			if (cmd.p6 && is_hg && last_q) begin
				grad_q <= sat16(64'(hsum >>> 24));
				acc_q  <= '0;
			end
			if (we)
				dvld_q[waddr] <= 1'b1;
			if (cmd.emit && stat.has_result)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	assign stat.has_result = (is_fwd && last_q) || is_og || (is_hg && last_q) || (is_upd && inr_q);
	assign stat.out_busy   = out_valid_q && !m_tready;
	assign m_tvalid        = out_valid_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && stat.has_result) |-> !(out_valid_q && !m_tready))
		else $error("result written over a beat not yet taken");
	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		(y_q <= 16'sd4096) && (y_q >= -16'sd4096))
		else $error("neuron output beyond +-1.0");
	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.p4 && is_fwd && last_q) |=> (acc_q == '0))
		else $error("accumulator not cleared after forward sum");
`endif
endmodule
`default_nettype wire

// File: src/backprop_neuron_engine.sv
// Top level of the backprop neuron engine: stream ports, APB registers,
// controller and datapath. Depends on bne_pkg, bne_ctrl, bne_datapath.
//
// Usage: request beats enter on the s_ channel (tuser = request type,
// tlast = last term of a forward or hidden gradient sum); results leave
// on the m_ channel (tuser = result kind). learning_rate and momentum sit
// on the APB port at byte addresses 0 and 4; the user is to write them only
// while idle, and the block does not enforce it. Each accepted beat walks
// six datapath phases, then a result slot; no new beat is accepted until
// the engine is back in idle. The result becomes valid in the cycle after the slot.
// Beats that give no result (non-last terms, loads, out-of-range updates or
// unknown requests) walk the same phases. A stalled output register holds the
// engine in the result slot; a beat without result passes through.
// Reset clears accumulator, output, gradient and delta valid bits and
// restores the register defaults; weights are undefined until loaded.
`default_nettype none
module backprop_neuron_engine #(
	parameter int MAX_INPUTS = bne_pkg::MAX_INPUTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // input_index[7:0], value_a[23:8], value_b[39:24]
	input  wire logic [2:0]  s_tuser,  // req_type
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,  // result_index[7:0], result_value[23:8]
	output logic [1:0]       m_tuser,  // result_kind
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import bne_pkg::*;

	logic [REG_W-1:0]        lr_q, mom_q;
	bne_cmd_t                cmd;
	bne_stat_t               stat;
	logic [IDX_W-1:0]        m_index;
	logic signed [VAL_W-1:0] m_value;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q  <= LR_RESET;
			mom_q <= MOM_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_MOM)
				mom_q <= pwdata[REG_W-1:0];
			else
				lr_q <= pwdata[REG_W-1:0];
		end
	end

	assign prdata = 32'((paddr[2] == REG_LR) ? lr_q : mom_q);

	bne_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready),
		.stat(stat), .cmd(cmd)
	);

	bne_datapath #(.MAX_INPUTS(MAX_INPUTS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .stat(stat),
		.in_req(s_tuser), .in_idx(s_tdata[7:0]),
		.in_a(s_tdata[23:8]), .in_b(s_tdata[39:24]), .in_last(s_tlast),
		.lr(lr_q), .mom(mom_q),
		.m_tready(m_tready), .m_tvalid(m_tvalid),
		.m_kind(m_tuser), .m_index(m_index), .m_value(m_value)
	);

	assign m_tdata = {m_value, m_index};
endmodule
`default_nettype wire
